>>> sv/brc_pkg.sv
// Shared types, constants and rounding helpers for the barometer compensation block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package brc_pkg;

	localparam int FRAC_BITS = 8;

	// register indexes (word address = byte address / 4)
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;

	// shared long divider geometry
	localparam int DIV_NW = 71;
	localparam int DIV_DW = 39;
	localparam int DIV_QW = 38;
	localparam int DIV_HW = DIV_NW - DIV_QW;

	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic        [15:0] ac4;
		logic        [15:0] ac5;
		logic        [15:0] ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
	} cal_t;

	// temperature front end to pressure back end
	typedef struct packed {
		logic signed [26:0] tw;
		logic signed [15:0] tout;
		logic               dz;
		logic        [23:0] rp;
	} temp_res_t;

	// round to nearest by 2^k, ties away from zero
	function automatic logic signed [71:0] rnd_sh(input logic signed [71:0] v, input int k);
		logic [71:0] mag;
		logic [71:0] q;
		mag = v[71] ? 72'(-v) : 72'(v);
		if (k == 0) begin
			q = mag;
		end else begin
			q = (mag + (72'd1 << (k - 1))) >> k;
		end
		return v[71] ? -$signed(q) : $signed(q);
	endfunction

endpackage

>>> sv/brc_regs.sv
// APB register file holding the five packed calibration registers.
// Depends on brc_pkg.
`timescale 1ns / 1ps
module brc_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output brc_pkg::cal_t      cal
);
	import brc_pkg::*;

	logic [31:0] r0_q, r1_q, r2_q, r3_q, r4_q;
	logic        wr;
	logic [2:0]  idx;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q <= '0;
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= '0;
			r4_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_AC1_AC2: r0_q <= pwdata;
				REG_AC3_AC4: r1_q <= pwdata;
				REG_AC5_AC6: r2_q <= pwdata;
				REG_B1_B2:   r3_q <= pwdata;
				REG_MC_MD:   r4_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_AC1_AC2: prdata = r0_q;
			REG_AC3_AC4: prdata = r1_q;
			REG_AC5_AC6: prdata = r2_q;
			REG_B1_B2:   prdata = r3_q;
			REG_MC_MD:   prdata = r4_q;
			default:     prdata = '0;
		endcase
	end

	assign cal.ac1 = $signed(r0_q[31:16]);
	assign cal.ac2 = $signed(r0_q[15:0]);
	assign cal.ac3 = $signed(r1_q[31:16]);
	assign cal.ac4 = r1_q[15:0];
	assign cal.ac5 = r2_q[31:16];
	assign cal.ac6 = r2_q[15:0];
	assign cal.b1  = $signed(r3_q[31:16]);
	assign cal.b2  = $signed(r3_q[15:0]);
	assign cal.mc  = $signed(r4_q[31:16]);
	assign cal.md  = $signed(r4_q[15:0]);

endmodule

>>> sv/brc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on brc_pkg for its fixed geometry.
`timescale 1ns / 1ps
module brc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [brc_pkg::DIV_NW-1:0] numer,
	input  logic [brc_pkg::DIV_DW-1:0] denom,
	output logic                       out_valid,
	output logic [brc_pkg::DIV_QW-1:0] quot,
	output logic                       ovf
);
	import brc_pkg::*;

	logic [DIV_DW-1:0] rem_s [DIV_QW];
	logic [DIV_DW-1:0] den_s [DIV_QW];
	logic [DIV_QW-1:0] low_s [DIV_QW];
	logic [DIV_QW-1:0] quo_s [DIV_QW];
	logic              ovf_s [DIV_QW];
	logic              vld_s [DIV_QW];

	logic [DIV_DW-1:0] rem_n [DIV_QW];
	logic [DIV_QW-1:0] low_n [DIV_QW];
	logic [DIV_QW-1:0] quo_n [DIV_QW];
	logic [DIV_DW-1:0] rem_p [DIV_QW];
	logic [DIV_DW-1:0] den_p [DIV_QW];
	logic [DIV_QW-1:0] low_p [DIV_QW];
	logic [DIV_QW-1:0] quo_p [DIV_QW];
	logic [DIV_DW:0]   trial [DIV_QW];
	logic              ge    [DIV_QW];
	logic              ovf_in;

	// quotient would not fit when the top numerator part already reaches the divisor
	assign ovf_in = DIV_DW'(numer[DIV_NW-1:DIV_QW]) >= denom;

	always_comb begin
		for (int k = 0; k < DIV_QW; k++) begin
			if (k == 0) begin
				rem_p[k] = DIV_DW'(numer[DIV_NW-1:DIV_QW]);
				den_p[k] = denom;
				low_p[k] = numer[DIV_QW-1:0];
				quo_p[k] = '0;
			end else begin
				rem_p[k] = rem_s[k-1];
				den_p[k] = den_s[k-1];
				low_p[k] = low_s[k-1];
				quo_p[k] = quo_s[k-1];
			end
			trial[k] = {rem_p[k], low_p[k][DIV_QW-1]};
			ge[k]    = trial[k] >= {1'b0, den_p[k]};
			rem_n[k] = ge[k] ? DIV_DW'(trial[k] - {1'b0, den_p[k]}) : trial[k][DIV_DW-1:0];
			low_n[k] = low_p[k] << 1;
			quo_n[k] = {quo_p[k][DIV_QW-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_QW; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < DIV_QW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= ovf_in;
			for (int k = 1; k < DIV_QW; k++) ovf_s[k] <= ovf_s[k-1];
			for (int k = 0; k < DIV_QW; k++) begin
				rem_s[k] <= rem_n[k];
				den_s[k] <= den_p[k];
				low_s[k] <= low_n[k];
				quo_s[k] <= quo_n[k];
			end
		end
	end

	assign out_valid = vld_s[DIV_QW-1];
	assign quot      = quo_s[DIV_QW-1];
	assign ovf       = ovf_s[DIV_QW-1];

endmodule

>>> sv/brc_temp.sv
// Temperature front end: linear and rational terms, clamp, output rounding.
// Depends on brc_pkg and brc_div.
`timescale 1ns / 1ps
module brc_temp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [15:0]         raw_temperature,
	input  logic [23:0]         raw_pressure,
	input  brc_pkg::cal_t       cal,
	output logic                out_valid,
	output brc_pkg::temp_res_t  res
);
	import brc_pkg::*;

	typedef struct packed {
		logic signed [27:0] ra;
		logic               qneg;
		logic               dz;
		logic        [23:0] rp;
	} tsb_t;

	localparam logic signed [30:0] TW_HI = 31'sd33554432;
	localparam logic signed [30:0] TW_LO = -31'sd33554432;
	localparam int TSH = 16 - FRAC_BITS;

	// stage 1
	logic signed [16:0] diff;
	logic signed [33:0] a_s1;
	logic        [23:0] rp_s1;
	logic               v_s1;
	// stage 2
	logic signed [34:0] d;
	logic        [32:0] a_abs;
	logic signed [37:0] d5_s2;
	logic        [28:0] am_s2;
	logic               an_s2, dz_s2, v_s2;
	logic        [23:0] rp_s2;
	// stage 3
	logic        [36:0] d5_abs;
	logic        [15:0] mc_abs;
	logic        [60:0] ra_prod;
	logic        [53:0] numer_s3;
	logic        [36:0] ad_s3;
	tsb_t               sb_s3;
	logic               v_s3;
	// divider
	tsb_t               sb_dl [DIV_QW];
	logic               dv;
	logic [DIV_QW-1:0]  dq;
	logic               dovf;
	// stage 4
	logic        [28:0] mag;
	logic signed [29:0] q2;
	logic signed [30:0] tw_full;
	logic signed [26:0] tw_s4;
	logic               dz_s4, v_s4;
	logic        [23:0] rp_s4;
	// stage 5
	logic signed [71:0] tr;
	logic signed [15:0] tout_n;

	assign diff = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ac6});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dv;
			out_valid <= v_s4;
		end
	end

	assign d      = 35'(a_s1) + (35'(cal.md) <<< 15);
	assign a_abs  = a_s1[33] ? 33'(-a_s1) : 33'(a_s1);
	assign d5_abs = d5_s2[37] ? 37'(-d5_s2) : 37'(d5_s2);
	assign mc_abs = cal.mc[15] ? 16'(-cal.mc) : 16'(cal.mc);
	// floor(x/5) by reciprocal, exact below 2^32
	assign ra_prod = 61'(am_s2) * 61'(32'hCCCCCCCD);

	always_comb begin
		mag = (dovf || (|dq[DIV_QW-1:28])) ? (29'd1 << 28) : {1'b0, dq[27:0]};
		q2  = sb_dl[DIV_QW-1].qneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		tw_full = 31'(sb_dl[DIV_QW-1].ra) + 31'(q2);
	end

	always_comb begin
		tr = rnd_sh(72'(tw_s4), TSH);
		if (tr > 72'sd32767) begin
			tout_n = 16'sh7FFF;
		end else if (tr < -72'sd32768) begin
			tout_n = -16'sh8000;
		end else begin
			tout_n = tr[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= 34'($signed({1'b0, cal.ac5})) * 34'(diff);
			rp_s1 <= raw_pressure;

			d5_s2 <= (38'(d) <<< 2) + 38'(d);
			am_s2 <= 29'((a_abs + 33'd40) >> 4);
			an_s2 <= a_s1[33];
			dz_s2 <= (d == '0);
			rp_s2 <= rp_s1;

			numer_s3 <= (54'(mc_abs) << 37) + 54'(d5_abs >> 1);
			ad_s3    <= d5_abs;
			sb_s3.ra <= an_s2 ? -$signed({1'b0, ra_prod[60:34]})
			                  : $signed({1'b0, ra_prod[60:34]});
			sb_s3.qneg <= cal.mc[15] ^ d5_s2[37];
			sb_s3.dz   <= dz_s2;
			sb_s3.rp   <= rp_s2;

			sb_dl[0] <= sb_s3;
			for (int k = 1; k < DIV_QW; k++) sb_dl[k] <= sb_dl[k-1];

			if (tw_full > TW_HI) begin
				tw_s4 <= 27'(TW_HI);
			end else if (tw_full < TW_LO) begin
				tw_s4 <= 27'(TW_LO);
			end else begin
				tw_s4 <= tw_full[26:0];
			end
			dz_s4 <= sb_dl[DIV_QW-1].dz;
			rp_s4 <= sb_dl[DIV_QW-1].rp;

			res.tw   <= tw_s4;
			res.tout <= tout_n;
			res.dz   <= dz_s4;
			res.rp   <= rp_s4;
		end
	end

	brc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.numer     (DIV_NW'(numer_s3)),
		.denom     (DIV_DW'(ad_s3)),
		.out_valid (dv),
		.quot      (dq),
		.ovf       (dovf)
	);

endmodule

>>> sv/brc_pres.sv
// Pressure back end: offset and scale quadratics, quotient, final quadratic.
// Depends on brc_pkg and brc_div; owns the output register.
`timescale 1ns / 1ps
module brc_pres (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  brc_pkg::temp_res_t  tin,
	input  brc_pkg::cal_t       cal,
	output logic                out_valid,
	output logic signed [15:0]  temperature,
	output logic [18:0]         pressure,
	output logic                fault
);
	import brc_pkg::*;

	typedef struct packed {
		logic signed [48:0] n;
		logic signed [15:0] tout;
		logic               dz;
		logic               vneg;
	} psb2_t;

	typedef struct packed {
		logic               zneg;
		logic               yz;
		logic signed [15:0] tout;
		logic               dz;
	} psb3_t;

	localparam int PSH = 24 - FRAC_BITS;
	localparam longint P0C = (longint'(3791 - 8) * 64'sd16777216 + 64'sd800) / 64'sd1600;
	localparam logic signed [21:0] K1 = 22'sd1041219;
	localparam logic [18:0] K2 = 19'd303800;
	// ceil(2^30 / 125); exact floor for 23-bit partial dividends
	localparam int R125_SH = 30;
	localparam logic [23:0] R125 = 24'd8589935;

	// common per-item tag for the early stages
	logic signed [15:0] tout_s1, tout_s2, tout_s3, tout_s4, tout_s5, tout_s6;
	logic               dz_s1, dz_s2, dz_s3, dz_s4, dz_s5, dz_s6;
	logic        [23:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s8, v_s9, v_s10;
	logic               v_s11, v_s12, v_s13, v_s14;
	logic               v_s7 [4];

	logic signed [27:0] sw_s1;
	logic        [55:0] sq_s2;
	logic signed [46:0] x2p_s2, g2p_s2, g2p_s3, g2p_s4;
	logic signed [18:0] k2, k3;
	logic signed [20:0] b25_1, b25_2;
	logic        [39:0] s2_s3;
	logic signed [38:0] x2_s3, x2_s4;
	logic signed [61:0] xb_s4, gb_s4;
	logic signed [47:0] x_s5;
	logic signed [39:0] gr_s5;
	logic signed [63:0] g;
	logic signed [48:0] n_s6;
	logic signed [56:0] v_prod_s6;
	logic        [56:0] v_abs;
	logic        [50:0] w;
	psb2_t              sb2_in;
	// divide by 125, one 16-bit digit per stage
	logic        [63:0] yw_s7 [3];
	logic         [6:0] yr_s7 [3];
	logic        [63:0] yq_s7 [4];
	psb2_t              sb2_s7 [4];
	logic        [63:0] yw_p  [4];
	logic         [6:0] yr_p  [4];
	logic        [63:0] yq_p  [4];
	logic        [22:0] ycur  [4];
	logic        [46:0] yprod [4];
	logic        [15:0] ydig  [4];
	logic         [6:0] yrem  [4];
	logic [DIV_QW-1:0]  ymag;
	logic        [48:0] n_abs;
	logic        [70:0] numer_s8;
	logic        [37:0] ay_s8;
	psb3_t              sb3_s8;
	psb3_t              sb3_dl [DIV_QW];
	logic               dv3;
	logic [DIV_QW-1:0]  dq3;
	logic               dovf3;
	logic        [34:0] zmag;
	logic signed [35:0] z_s9;
	logic signed [29:0] zh_s10;
	logic signed [57:0] zl_s10;
	logic        [59:0] zsq_s11;
	logic signed [45:0] zl2_s11, zl2_s12, zl2_s13;
	logic        [43:0] zs_s12;
	logic        [62:0] pa_s13;
	logic signed [48:0] p_s14;
	psb3_t              sb3_s9, sb3_s10, sb3_s11, sb3_s12, sb3_s13, sb3_s14;
	logic signed [71:0] pr;
	logic        [18:0] pr_sat;

	assign k2    = 19'(cal.ac2) * 19'sd5;
	assign k3    = 19'(cal.ac3) * 19'sd5;
	assign b25_1 = 21'(cal.b1) * 21'sd25;
	assign b25_2 = 21'(cal.b2) * 21'sd25;

	assign g = 64'(gb_s4) + (64'(g2p_s4) <<< 10) + (64'sd1 <<< 51);

	// rnd(v, 8000) = floor(floor((|v| + 4000) / 64) / 125)
	assign v_abs = v_prod_s6[56] ? 57'(-v_prod_s6) : 57'(v_prod_s6);
	assign w     = 51'((v_abs + 57'd4000) >> 6);

	assign sb2_in.n    = n_s6;
	assign sb2_in.tout = tout_s6;
	assign sb2_in.dz   = dz_s6;
	assign sb2_in.vneg = v_prod_s6[56];

	// long division by 125: remainder below 125 keeps each partial dividend in 23 bits
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (k == 0) begin
				yw_p[k] = 64'(w);
				yr_p[k] = '0;
				yq_p[k] = '0;
			end else begin
				yw_p[k] = yw_s7[k-1];
				yr_p[k] = yr_s7[k-1];
				yq_p[k] = yq_s7[k-1];
			end
			ycur[k]  = {yr_p[k], yw_p[k][63:48]};
			yprod[k] = 47'(ycur[k]) * 47'(R125);
			ydig[k]  = 16'(yprod[k] >> R125_SH);
			yrem[k]  = 7'(ycur[k] - 23'(ydig[k]) * 23'd125);
		end
	end

	assign ymag = yq_s7[3][DIV_QW-1:0];

	assign n_abs = sb2_s7[3].n[48] ? 49'(-sb2_s7[3].n) : 49'(sb2_s7[3].n);

	assign zmag = (dovf3 || (dq3 > (38'd1 << 34))) ? (35'd1 << 34) : dq3[34:0];

	always_comb begin
		pr = rnd_sh(72'(p_s14), PSH);
		if (pr < 72'sd0) begin
			pr_sat = '0;
		end else if (pr > 72'sd524287) begin
			pr_sat = 19'h7FFFF;
		end else begin
			pr_sat = pr[18:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			for (int k = 0; k < 4; k++) v_s7[k] <= 1'b0;
			{v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14} <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7[0] <= v_s6;
			for (int k = 1; k < 4; k++) v_s7[k] <= v_s7[k-1];
			v_s8  <= v_s7[3];
			v_s9  <= dv3;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			out_valid <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sw_s1   <= 28'(tin.tw) - 28'sd1638400;
			tout_s1 <= tin.tout;
			dz_s1   <= tin.dz;
			rp_s1   <= tin.rp;

			sq_s2   <= 56'(56'(sw_s1) * 56'(sw_s1));
			x2p_s2  <= 47'(k2) * 47'(sw_s1);
			g2p_s2  <= 47'(k3) * 47'(sw_s1);
			{tout_s2, dz_s2, rp_s2} <= {tout_s1, dz_s1, rp_s1};

			s2_s3   <= 40'((sq_s2 + 56'd32768) >> 16);
			x2_s3   <= 39'(rnd_sh(72'(x2p_s2), 8));
			g2p_s3  <= g2p_s2;
			{tout_s3, dz_s3, rp_s3} <= {tout_s2, dz_s2, rp_s2};

			xb_s4   <= 62'(b25_2) * 62'($signed({1'b0, s2_s3}));
			gb_s4   <= 62'(b25_1) * 62'($signed({1'b0, s2_s3}));
			x2_s4   <= x2_s3;
			g2p_s4  <= g2p_s3;
			{tout_s4, dz_s4, rp_s4} <= {tout_s3, dz_s3, rp_s3};

			x_s5    <= 48'(rnd_sh(72'(xb_s4), 15)) + 48'(x2_s4) + (48'(cal.ac1) <<< 16);
			gr_s5   <= 40'(rnd_sh(72'(g), 24));
			{tout_s5, dz_s5, rp_s5} <= {tout_s4, dz_s4, rp_s4};

			n_s6      <= $signed({17'd0, rp_s5, 8'd0}) - 49'(x_s5);
			v_prod_s6 <= 57'($signed({1'b0, cal.ac4})) * 57'(gr_s5);
			{tout_s6, dz_s6} <= {tout_s5, dz_s5};

			for (int k = 0; k < 3; k++) begin
				yw_s7[k] <= yw_p[k] << 16;
				yr_s7[k] <= yrem[k];
			end
			for (int k = 0; k < 4; k++) yq_s7[k] <= {yq_p[k][47:0], ydig[k]};
			sb2_s7[0] <= sb2_in;
			for (int k = 1; k < 4; k++) sb2_s7[k] <= sb2_s7[k-1];

			numer_s8 <= {n_abs[45:0], 24'd0} + 70'(ymag >> 1);
			ay_s8    <= ymag;
			sb3_s8.zneg <= sb2_s7[3].n[48] ^ sb2_s7[3].vneg;
			sb3_s8.yz   <= (ymag == '0);
			sb3_s8.tout <= sb2_s7[3].tout;
			sb3_s8.dz   <= sb2_s7[3].dz;

			sb3_dl[0] <= sb3_s8;
			for (int k = 1; k < DIV_QW; k++) sb3_dl[k] <= sb3_dl[k-1];

			z_s9   <= sb3_dl[DIV_QW-1].zneg ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
			sb3_s9 <= sb3_dl[DIV_QW-1];

			zh_s10  <= 30'(rnd_sh(72'(z_s9), 6));
			zl_s10  <= 58'(K1) * 58'(z_s9);
			sb3_s10 <= sb3_s9;

			zsq_s11 <= 60'(60'(zh_s10) * 60'(zh_s10));
			zl2_s11 <= 46'(rnd_sh(72'(zl_s10), 12));
			sb3_s11 <= sb3_s10;

			zs_s12  <= 44'((zsq_s11 + 60'd32768) >> 16);
			zl2_s12 <= zl2_s11;
			sb3_s12 <= sb3_s11;

			pa_s13  <= 63'(K2) * 63'(zs_s12);
			zl2_s13 <= zl2_s12;
			sb3_s13 <= sb3_s12;

			p_s14   <= $signed({2'b0, 47'((pa_s13 + 63'd32768) >> 16)}) + 49'(zl2_s13)
			         + 49'(P0C);
			sb3_s14 <= sb3_s13;

			temperature <= sb3_s14.dz ? 16'sd0 : sb3_s14.tout;
			pressure    <= (sb3_s14.dz || sb3_s14.yz) ? 19'd0 : pr_sat;
			fault       <= sb3_s14.dz || sb3_s14.yz;
		end
	end

	brc_div u_div_quot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.numer     (DIV_NW'(numer_s8)),
		.denom     (DIV_DW'(ay_s8)),
		.out_valid (dv3),
		.quot      (dq3),
		.ovf       (dovf3)
	);

endmodule

>>> sv/barometer_reading_compensation_top.sv
// Barometer reading compensation: stream in, stream out, APB calibration port.
// Instantiates brc_regs, brc_temp and brc_pres; depends on brc_pkg.
//
// Usage:
//  - Write the five calibration registers over APB (byte address 4*i) while the
//    block is idle. Reads return the stored value; pready is always high.
//  - Input items on s_*: raw temperature and raw pressure in s_tdata.
//  - Result items on m_*: temperature and pressure in m_tdata, fault in m_tuser.
//  - One item per cycle is accepted as long as the output is taken; the latency is
//    set mostly by two 38-stage one-bit-per-stage divider pipelines
//    (rational temperature term, pressure quotient) plus a four-stage divide
//    by 125 for the scale term.
//  - The whole pipeline advances together: when a result waits in the output
//    register and m_tready is low, every stage holds and s_tready drops, so
//    nothing is lost or repeated.
//  - Reset clears the calibration registers and all valid bits; no item is in
//    flight after reset.
//  - fault marks a zero divisor; temperature or pressure are then forced to 0.
`timescale 1ns / 1ps
module barometer_reading_compensation_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [15:0] raw_temperature, [39:16] raw_pressure
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [15:0] temperature, [34:16] pressure, rest zero
	output logic        m_tuser   // [0] fault
);
	import brc_pkg::*;

	cal_t               cal;
	temp_res_t          tres;
	logic               tvalid;
	logic               en;
	logic signed [15:0] temperature;
	logic        [18:0] pressure;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	brc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	brc_temp u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (s_tvalid),
		.raw_temperature (s_tdata[15:0]),
		.raw_pressure    (s_tdata[39:16]),
		.cal             (cal),
		.out_valid       (tvalid),
		.res             (tres)
	);

	brc_pres u_pres (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (tvalid),
		.tin         (tres),
		.cal         (cal),
		.out_valid   (m_tvalid),
		.temperature (temperature),
		.pressure    (pressure),
		.fault       (m_tuser)
	);

	assign m_tdata = {5'd0, pressure, temperature};

endmodule

>>> verif/tb_top.sv
// Testbench for barometer_reading_compensation_top: random and directed items
// checked against a cycle-free predictor of the compensation arithmetic.
// Depends on brc_pkg and the RTL under sv/.
`timescale 1ns / 1ps
module tb_top;
	import brc_pkg::*;

	localparam int LATENCY = 99;
	localparam int CYCLE_LIMIT = 400000;

	// raw_temp in the low bits, as on s_tdata
	typedef struct packed {
		logic [23:0] raw_pres;
		logic [15:0] raw_temp;
	} reading_t;

	typedef struct packed {
		logic signed [15:0] temp;
		logic [18:0] pres;
		logic fault;
	} comp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;   // [15:0] raw_temperature, [39:16] raw_pressure
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;        // [15:0] temperature, [34:16] pressure
	logic m_tuser;               // [0] fault

	barometer_reading_compensation_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [31:0] cal [5];
	reading_t readings_pending[$];
	comp_t comp_expected[$];
	int unsigned n_errors = 0, n_results = 0, n_faults = 0, n_cycles = 0;
	logic item_taken = 1'b0;

	// n/d rounded to nearest, ties away from zero
	function automatic longint rnd(longint n, longint d);
		longint unsigned an, ad, q;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		if (ad == 0) return 0;
		q = (an + ad / 2) / ad;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint sw16(logic [15:0] w);
		return longint'($signed(w));
	endfunction

	// pressure quotient in Q24 with magnitude capped at 2^34
	function automatic longint quot_cap(longint n, longint y);
		longint unsigned an, ay, q, r, mag;
		an = n < 0 ? -n : n;
		ay = y < 0 ? -y : y;
		q = an / ay;
		r = an % ay;
		if (q >= 1024) begin
			mag = 64'd1 << 34;
		end else begin
			mag = (q << 24) + ((r << 24) + ay / 2) / ay;
			if (mag > (64'd1 << 34)) mag = 64'd1 << 34;
		end
		return ((n < 0) != (y < 0)) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic comp_t compensate(reading_t rd);
		comp_t res;
		longint tu, rp, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		longint a, d, tw, tout, sw, s2, x, g, y, n, z, zh, zs, p;
		tu = longint'(rd.raw_temp);
		rp = longint'(rd.raw_pres);
		ac1 = sw16(cal[REG_AC1_AC2][31:16]); ac2 = sw16(cal[REG_AC1_AC2][15:0]);
		ac3 = sw16(cal[REG_AC3_AC4][31:16]); ac4 = longint'(cal[REG_AC3_AC4][15:0]);
		ac5 = longint'(cal[REG_AC5_AC6][31:16]); ac6 = longint'(cal[REG_AC5_AC6][15:0]);
		b1 = sw16(cal[REG_B1_B2][31:16]); b2 = sw16(cal[REG_B1_B2][15:0]);
		mc = sw16(cal[REG_MC_MD][31:16]); md = sw16(cal[REG_MC_MD][15:0]);
		res = '0;
		a = ac5 * (tu - ac6);
		d = a + md * 32768;
		if (d == 0) begin
			res.fault = 1'b1;
			return res;
		end
		tw = rnd(a, 80) + rnd(mc * (64'sd1 <<< 37), 5 * d);
		if (tw > 512 * 65536) tw = 512 * 65536;
		if (tw < -512 * 65536) tw = -512 * 65536;
		tout = rnd(tw, 64'sd1 <<< (16 - FRAC_BITS));
		if (tout > 32767) tout = 32767;
		if (tout < -32768) tout = -32768;
		res.temp = tout[15:0];
		sw = tw - 25 * 65536;
		s2 = rnd(sw * sw, 65536);
		x = rnd(25 * b2 * s2, 32768) + rnd(5 * ac2 * sw, 256) + ac1 * 65536;
		g = 25 * b1 * s2 + 5120 * ac3 * sw + (64'sd1 <<< 51);
		y = rnd(ac4 * rnd(g, 64'sd1 <<< 24), 8000);
		if (y == 0) begin
			res.fault = 1'b1;
			return res;
		end
		n = rp * 256 - x;
		z = quot_cap(n, y);
		zh = rnd(z, 64);
		zs = rnd(zh * zh, 65536);
		p = rnd(64'sd303800 * zs, 65536) + rnd((64'sd1048576 - 7357) * z, 4096)
			+ rnd(64'sd3783 * 16777216, 1600);
		p = rnd(p, 64'sd1 <<< (24 - FRAC_BITS));
		if (p < 0) p = 0;
		if (p > 524287) p = 524287;
		res.pres = p[18:0];
		return res;
	endfunction

	// sender: bursts with random gaps
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !item_taken)) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (readings_pending.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= readings_pending.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall mode picked at random among four patterns
	int stall_mode = 0;
	always @(negedge clk) begin
		if (n_cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (n_cycles % 7) < 3;
		endcase
	end

	// monitor
	always @(posedge clk) begin
		comp_t got, want;
		n_cycles <= n_cycles + 1;
		item_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			comp_expected.push_back(compensate(reading_t'(s_tdata)));
		if (arst_n && m_tvalid && m_tready) begin
			got.temp = m_tdata[15:0];
			got.pres = m_tdata[34:16];
			got.fault = m_tuser;
			n_results <= n_results + 1;
			if (m_tuser) n_faults <= n_faults + 1;
			if (comp_expected.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("ERROR: unexpected result %p", got);
			end else begin
				want = comp_expected.pop_front();
				if (got !== want || m_tdata[39:35] !== '0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: exp temp %0d pres %0d fault %0b, got %0d %0d %0b",
							want.temp, want.pres, want.fault,
							got.temp, got.pres, got.fault);
				end
			end
		end
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", n_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic cal_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		cal[idx] = val;
	endtask

	task automatic cal_set(logic [31:0] v0, v1, v2, v3, v4);
		cal_write(REG_AC1_AC2, v0);
		cal_write(REG_AC3_AC4, v1);
		cal_write(REG_AC5_AC6, v2);
		cal_write(REG_B1_B2, v3);
		cal_write(REG_MC_MD, v4);
	endtask

	task automatic drain;
		while (readings_pending.size() > 0 || s_tvalid || comp_expected.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic add(logic [15:0] tu, logic [23:0] rp);
		readings_pending.push_back(reading_t'{raw_pres: rp, raw_temp: tu});
	endtask

	// plausible raw pair around a typical operating point
	task automatic add_typical;
		add(16'(27898 + $urandom_range(0, 12000) - 6000),
			24'(((23843 + $urandom_range(0, 16000) - 8000) << 8) | $urandom_range(0, 255)));
	endtask

	task automatic add_any;
		add(16'($urandom), 24'($urandom));
	endtask

	// typical factory calibration
	localparam logic [31:0] TYP0 = {16'sd408, -16'sd72};
	localparam logic [31:0] TYP1 = {-16'sd14383, 16'd32741};
	localparam logic [31:0] TYP2 = {16'd32757, 16'd23153};
	localparam logic [31:0] TYP3 = {16'sd6190, 16'sd4};
	localparam logic [31:0] TYP4 = {-16'sd8711, 16'sd2868};

	initial begin
		for (int i = 0; i < 5; i++) cal[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset calibration: temperature divisor is zero
		add(16'h0000, 24'h000000); add(16'hFFFF, 24'hFFFFFF); add(16'h5555, 24'hAAAAAA);
		drain();

		cal_set(TYP0, TYP1, TYP2, TYP3, TYP4);
		add(16'd27898, 24'd23843 << 8);
		add(16'h0000, 24'h000000); add(16'hFFFF, 24'hFFFFFF);
		add(16'h0000, 24'hFFFFFF); add(16'hFFFF, 24'h000000);
		add(16'hAAAA, 24'h555555); add(16'h5555, 24'hAAAAAA);
		add(16'd23153, 24'd20000 << 8);
		for (int i = 0; i < 350; i++) begin
			if ($urandom_range(0, 4) == 0) add_any(); else add_typical();
			// one pause that lets everything drain
			if (i == 120) drain();
		end
		drain();

		// temperature divisor zero at tu == AC6 when MD is zero
		cal_write(REG_MC_MD, {-16'sd8711, 16'sd0});
		add(16'd23153, 24'h5D2300); add(16'd23154, 24'h5D2300); add(16'd23152, 24'h5D2300);
		drain();

		// scale divisor zero; extreme temperature from a tiny divisor
		cal_set(TYP0, {-16'sd14383, 16'd0}, TYP2, TYP3, TYP4);
		add(16'd27898, 24'h5D2300); add(16'hFFFF, 24'hFFFFFF);
		drain();
		cal_set(TYP0, {-16'sd14383, 16'd1}, {16'd1, 16'd0}, TYP3, {16'sh7FFF, 16'sd0});
		add(16'd1, 24'hFFFFFF); add(16'd2, 24'h000000); add(16'hFFFF, 24'h800000);
		for (int i = 0; i < 20; i++) add_any();
		drain();

		// extremes of the calibration words
		cal_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 60; i++) add_any();
		drain();
		cal_set(32'h8000_8000, 32'h8000_0000, 32'h0000_0000, 32'h8000_8000, 32'h8000_8000);
		for (int i = 0; i < 30; i++) add_any();
		drain();
		cal_set(32'h7FFF_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
		for (int i = 0; i < 30; i++) add_any();
		drain();

		// random calibrations, some near typical
		for (int ph = 0; ph < 6; ph++) begin
			if (ph % 2 == 0)
				cal_set($urandom, $urandom, $urandom, $urandom, $urandom);
			else
				cal_set(TYP0 ^ 32'($urandom_range(0, 255)), TYP1 ^ 32'($urandom_range(0, 255)),
					TYP2 ^ 32'($urandom_range(0, 255)), TYP3 ^ 32'($urandom_range(0, 7)),
					TYP4 ^ 32'($urandom_range(0, 255)));
			for (int i = 0; i < 55; i++) begin
				if (ph % 2 == 0 || $urandom_range(0, 3) == 0) add_any(); else add_typical();
			end
			drain();
		end

		$display("Covered %0d results (%0d with fault) over reset, typical, extreme",
			n_results, n_faults);
		$display("and random calibrations with random idle and stall patterns.");
		if (n_errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
